// ----- sv/bprm_pkg.sv -----
// Shared types and constants for the breath and pulse rate monitor.
// No dependencies; used by all bprm modules by scoped name.
package bprm_pkg;

  localparam int unsigned RATE_BITS    = 16;
  localparam int unsigned CNT_BITS     = $clog2(RATE_BITS);
  localparam int unsigned CFG_BITS     = 16;
  localparam int unsigned CFG_IDX_BITS = 3;

  localparam logic [RATE_BITS-1:0] RATE_SAT = {RATE_BITS{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_RESP_ARM   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESP_FIRE  = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_THR  = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] REG_NUMERATOR  = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] REG_RESP_PER   = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_PER  = 3'd5;

  localparam logic [CFG_BITS-1:0] NUMERATOR_RST = 16'd60000;
  localparam logic [CFG_BITS-1:0] RESP_PER_RST  = 16'd100;
  localparam logic [CFG_BITS-1:0] PULSE_PER_RST = 16'd50;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ----- sv/bprm_div.sv -----
// Shared radix-2 restoring divider: 16-bit dividend by a time interval.
// One quotient bit per cycle; zero divisor saturates. Uses bprm_pkg.
module bprm_div #(
  parameter int unsigned DIVISOR_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [bprm_pkg::RATE_BITS-1:0] dividend_i,
  input  logic [DIVISOR_BITS-1:0]        divisor_i,
  output bprm_pkg::div_stat_t            stat_o,
  output logic [bprm_pkg::RATE_BITS-1:0] quotient_o
);

  localparam int unsigned RB = bprm_pkg::RATE_BITS;

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [bprm_pkg::CNT_BITS-1:0]    cnt_q, cnt_d;
  logic [RB-1:0]                    rem_q, rem_d;
  logic [RB-1:0]                    quo_q, quo_d;
  logic [DIVISOR_BITS-1:0]          dvs_q, dvs_d;

  logic [RB:0]             trial;
  logic [DIVISOR_BITS:0]   trial_ext;
  logic [DIVISOR_BITS:0]   diff;
  logic                    fits;

  assign trial     = {rem_q, quo_q[RB-1]};
  assign trial_ext = (DIVISOR_BITS+1)'(trial);
  assign fits      = trial_ext >= {1'b0, dvs_q};
  assign diff      = trial_ext - {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      if (divisor_i == '0) begin
        quo_d  = bprm_pkg::RATE_SAT;
        done_d = 1'b1;
      end else begin
        busy_d = 1'b1;
        cnt_d  = '0;
        rem_d  = '0;
        quo_d  = dividend_i;
        dvs_d  = divisor_i;
      end
    end else if (busy_q) begin
      rem_d = fits ? diff[RB-1:0] : trial[RB-1:0];
      quo_d = {quo_q[RB-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == bprm_pkg::CNT_BITS'(RB-1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign quotient_o  = quo_q;

  start_when_idle_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");

  finish_after_run_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_q) |-> done_q) else $error("divider run ended without done");

  busy_not_done_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !done_q) else $error("divider busy and done together");

endmodule

// ----- sv/bprm_hold.sv -----
// Held rate with running minimum and maximum for one channel.
// Uses bprm_pkg for the rate width.
module bprm_hold (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           upd_i,
  input  logic [bprm_pkg::RATE_BITS-1:0] rate_i,
  output logic [bprm_pkg::RATE_BITS-1:0] rate_o,
  output logic [bprm_pkg::RATE_BITS-1:0] min_o,
  output logic [bprm_pkg::RATE_BITS-1:0] max_o
);

  logic [bprm_pkg::RATE_BITS-1:0] rate_q, rate_d;
  logic [bprm_pkg::RATE_BITS-1:0] min_q, min_d;
  logic [bprm_pkg::RATE_BITS-1:0] max_q, max_d;

  always_comb begin
    rate_d = rate_q;
    min_d  = min_q;
    max_d  = max_q;
    if (upd_i) begin
      rate_d = rate_i;
      // a zero in either bound restarts tracking from this rate
      if (min_q == '0 || max_q == '0) begin
        min_d = rate_i;
        max_d = rate_i;
      end else begin
        if (rate_i < min_q) min_d = rate_i;
        if (rate_i > max_q) max_d = rate_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
    end else begin
      rate_q <= rate_d;
      min_q  <= min_d;
      max_q  <= max_d;
    end
  end

  assign rate_o = rate_q;
  assign min_o  = min_q;
  assign max_o  = max_q;

endmodule

// ----- sv/breath_and_pulse_rate_monitor.sv -----
// Top level: sample window, peak detectors, report timers and sequencer.
// Uses bprm_pkg, bprm_div (shared divider) and bprm_hold (one per channel).
// Sequence: an accepted transaction passes the detection, breath division, pulse division
//   and output states; a due report runs the shared bit-serial divider for its channel.
// One item at a time: the next is taken once the sequencer is back in idle, while a
//   finished result may still wait in the output register.
// Reset: asynchronous, clears window, detectors, counters, held rates; config to defaults.
module breath_and_pulse_rate_monitor #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned TIME_BITS   = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  logic [bprm_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic [bprm_pkg::CFG_BITS-1:0]         cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [TIME_BITS-1:0]                  time_stamp_i,
  input  logic signed [SAMPLE_BITS-1:0]         resp_sample_i,
  input  logic signed [SAMPLE_BITS-1:0]         pulse_sample_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  resp_report_o,
  output logic [bprm_pkg::RATE_BITS-1:0]        resp_rate_o,
  output logic [bprm_pkg::RATE_BITS-1:0]        resp_rate_min_o,
  output logic [bprm_pkg::RATE_BITS-1:0]        resp_rate_max_o,
  output logic                                  pulse_report_o,
  output logic [bprm_pkg::RATE_BITS-1:0]        pulse_rate_o,
  output logic [bprm_pkg::RATE_BITS-1:0]        pulse_rate_min_o,
  output logic [bprm_pkg::RATE_BITS-1:0]        pulse_rate_max_o
);

  localparam int unsigned CW  = bprm_pkg::CFG_BITS;
  localparam int unsigned RB  = bprm_pkg::RATE_BITS;
  localparam int unsigned CMP = (SAMPLE_BITS > CW) ? SAMPLE_BITS : CW;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DET  = 5'b00010,
    S_RDIV = 5'b00100,
    S_PDIV = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic signed [CW-1:0] arm_q, fire_q, pthr_q;
  logic [CW-1:0]        num_q, rper_q, pper_q;

  // latched transaction
  logic [TIME_BITS-1:0]          in_time_q;
  logic signed [SAMPLE_BITS-1:0] in_resp_q, in_pulse_q;

  // window and detector state
  logic signed [SAMPLE_BITS-1:0] resp_mid_q, resp_mid_d;
  logic signed [SAMPLE_BITS-1:0] pulse_old_q, pulse_old_d;
  logic signed [SAMPLE_BITS-1:0] pulse_mid_q, pulse_mid_d;
  logic [TIME_BITS-1:0]          mid_time_q, mid_time_d;
  logic [1:0]                    fill_q, fill_d;
  logic                          armed_q, armed_d;
  logic [TIME_BITS-1:0]          resp_t0_q, resp_t0_d, resp_t1_q, resp_t1_d;
  logic [TIME_BITS-1:0]          pulse_t0_q, pulse_t0_d, pulse_t1_q, pulse_t1_d;
  logic [1:0]                    resp_pk_q, resp_pk_d, pulse_pk_q, pulse_pk_d;
  logic [CW-1:0]                 resp_per_q, resp_per_d, pulse_per_q, pulse_per_d;
  logic                          resp_due_q, resp_due_d, pulse_due_q, pulse_due_d;

  // output register
  logic          out_valid_q, out_valid_d;
  logic          o_rrep_q, o_prep_q;
  logic [RB-1:0] o_rrate_q, o_rmin_q, o_rmax_q, o_prate_q, o_pmin_q, o_pmax_q;

  logic signed [CMP-1:0] c_rmid, c_rnew, c_pold, c_pmid, c_pnew, c_arm, c_fire, c_pthr;
  logic                  arm_now, armed_mid, resp_fire, pulse_fire;
  logic [CW:0]           resp_per_inc, pulse_per_inc;

  logic                  div_start;
  logic [TIME_BITS-1:0]  div_divisor;
  bprm_pkg::div_stat_t   div_stat;
  logic [RB-1:0]         div_quo;
  logic                  r_proceed, p_proceed, out_load;

  logic [RB-1:0] r_rate, r_min, r_max, p_rate, p_min, p_max;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      arm_q  <= '0;
      fire_q <= '0;
      pthr_q <= '0;
      num_q  <= bprm_pkg::NUMERATOR_RST;
      rper_q <= bprm_pkg::RESP_PER_RST;
      pper_q <= bprm_pkg::PULSE_PER_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bprm_pkg::REG_RESP_ARM:  arm_q  <= cfg_data_i;
        bprm_pkg::REG_RESP_FIRE: fire_q <= cfg_data_i;
        bprm_pkg::REG_PULSE_THR: pthr_q <= cfg_data_i;
        bprm_pkg::REG_NUMERATOR: num_q  <= cfg_data_i;
        bprm_pkg::REG_RESP_PER:  rper_q <= cfg_data_i;
        bprm_pkg::REG_PULSE_PER: pper_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_time_q  <= time_stamp_i;
      in_resp_q  <= resp_sample_i;
      in_pulse_q <= pulse_sample_i;
    end
  end

  // signed compares at the wider of sample and level widths
  assign c_rmid = CMP'(resp_mid_q);
  assign c_rnew = CMP'(in_resp_q);
  assign c_pold = CMP'(pulse_old_q);
  assign c_pmid = CMP'(pulse_mid_q);
  assign c_pnew = CMP'(in_pulse_q);
  assign c_arm  = CMP'(arm_q);
  assign c_fire = CMP'(fire_q);
  assign c_pthr = CMP'(pthr_q);

  assign arm_now    = (c_rmid < c_arm) && (c_rmid > c_rnew);
  assign armed_mid  = armed_q || arm_now;    // arm and fire may happen on one sample
  assign resp_fire  = (fill_q == 2'd2) && armed_mid && (c_rmid > c_fire);
  assign pulse_fire = (fill_q == 2'd2) && (c_pmid >= c_pold) && (c_pmid > c_pnew)
                      && (c_pmid > c_pthr);

  assign resp_per_inc  = {1'b0, resp_per_q} + 1'b1;
  assign pulse_per_inc = {1'b0, pulse_per_q} + 1'b1;

  assign r_proceed = !resp_due_q || div_stat.done;
  assign p_proceed = !pulse_due_q || div_stat.done;
  assign out_load  = (state_q == S_OUT) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d     = state_q;
    resp_mid_d  = resp_mid_q;
    pulse_old_d = pulse_old_q;
    pulse_mid_d = pulse_mid_q;
    mid_time_d  = mid_time_q;
    fill_d      = fill_q;
    armed_d     = armed_q;
    resp_t0_d   = resp_t0_q;
    resp_t1_d   = resp_t1_q;
    pulse_t0_d  = pulse_t0_q;
    pulse_t1_d  = pulse_t1_q;
    resp_pk_d   = resp_pk_q;
    pulse_pk_d  = pulse_pk_q;
    resp_per_d  = resp_per_q;
    pulse_per_d = pulse_per_q;
    resp_due_d  = resp_due_q;
    pulse_due_d = pulse_due_q;
    out_valid_d = out_valid_q && !out_ready_i;
    div_start   = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DET;
      end
      S_DET: begin
        if (fill_q == 2'd2) armed_d = armed_mid && !resp_fire;
        if (resp_fire) begin
          resp_t0_d = resp_t1_q;
          resp_t1_d = mid_time_q;
          if (resp_pk_q != 2'd2) resp_pk_d = resp_pk_q + 1'b1;
        end
        if (pulse_fire) begin
          pulse_t0_d = pulse_t1_q;
          pulse_t1_d = mid_time_q;
          if (pulse_pk_q != 2'd2) pulse_pk_d = pulse_pk_q + 1'b1;
        end
        resp_due_d  = (resp_per_q == '0) && (resp_pk_d == 2'd2);
        pulse_due_d = (pulse_per_q == '0) && (pulse_pk_d == 2'd2);
        resp_per_d  = (resp_per_inc >= {1'b0, rper_q}) ? '0 : resp_per_inc[CW-1:0];
        pulse_per_d = (pulse_per_inc >= {1'b0, pper_q}) ? '0 : pulse_per_inc[CW-1:0];
        resp_mid_d  = in_resp_q;
        pulse_old_d = pulse_mid_q;
        pulse_mid_d = in_pulse_q;
        mid_time_d  = in_time_q;
        if (fill_q != 2'd2) fill_d = fill_q + 1'b1;
        div_start   = resp_due_d;
        state_d     = S_RDIV;
      end
      S_RDIV: begin
        if (r_proceed) begin
          div_start = pulse_due_q;
          state_d   = S_PDIV;
        end
      end
      S_PDIV: begin
        if (p_proceed) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // resp interval comes from the peak times being written this cycle
  assign div_divisor = (state_q == S_DET) ? (resp_t1_d - resp_t0_d)
                                          : (pulse_t1_q - pulse_t0_q);

  bprm_div #(
    .DIVISOR_BITS(TIME_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (div_divisor),
    .stat_o     (div_stat),
    .quotient_o (div_quo)
  );

  bprm_hold u_resp_hold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  ((state_q == S_RDIV) && resp_due_q && div_stat.done),
    .rate_i (div_quo),
    .rate_o (r_rate),
    .min_o  (r_min),
    .max_o  (r_max)
  );

  bprm_hold u_pulse_hold (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .upd_i  ((state_q == S_PDIV) && pulse_due_q && div_stat.done),
    .rate_i (div_quo),
    .rate_o (p_rate),
    .min_o  (p_min),
    .max_o  (p_max)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      resp_mid_q  <= '0;
      pulse_old_q <= '0;
      pulse_mid_q <= '0;
      mid_time_q  <= '0;
      fill_q      <= '0;
      armed_q     <= 1'b0;
      resp_t0_q   <= '0;
      resp_t1_q   <= '0;
      pulse_t0_q  <= '0;
      pulse_t1_q  <= '0;
      resp_pk_q   <= '0;
      pulse_pk_q  <= '0;
      resp_per_q  <= '0;
      pulse_per_q <= '0;
      resp_due_q  <= 1'b0;
      pulse_due_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      resp_mid_q  <= resp_mid_d;
      pulse_old_q <= pulse_old_d;
      pulse_mid_q <= pulse_mid_d;
      mid_time_q  <= mid_time_d;
      fill_q      <= fill_d;
      armed_q     <= armed_d;
      resp_t0_q   <= resp_t0_d;
      resp_t1_q   <= resp_t1_d;
      pulse_t0_q  <= pulse_t0_d;
      pulse_t1_q  <= pulse_t1_d;
      resp_pk_q   <= resp_pk_d;
      pulse_pk_q  <= pulse_pk_d;
      resp_per_q  <= resp_per_d;
      pulse_per_q <= pulse_per_d;
      resp_due_q  <= resp_due_d;
      pulse_due_q <= pulse_due_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      o_rrep_q  <= resp_due_q;
      o_rrate_q <= r_rate;
      o_rmin_q  <= r_min;
      o_rmax_q  <= r_max;
      o_prep_q  <= pulse_due_q;
      o_prate_q <= p_rate;
      o_pmin_q  <= p_min;
      o_pmax_q  <= p_max;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign resp_report_o    = o_rrep_q;
  assign resp_rate_o      = o_rrate_q;
  assign resp_rate_min_o  = o_rmin_q;
  assign resp_rate_max_o  = o_rmax_q;
  assign pulse_report_o   = o_prep_q;
  assign pulse_rate_o     = o_prate_q;
  assign pulse_rate_min_o = o_pmin_q;
  assign pulse_rate_max_o = o_pmax_q;

  accept_starts_det_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_DET))
    else $error("accepted transaction did not enter detection");

  result_from_out_state_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result raised outside the output state");

  report_needs_two_peaks_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && (resp_due_q || pulse_due_q)) |->
      ((!resp_due_q || resp_pk_q == 2'd2) && (!pulse_due_q || pulse_pk_q == 2'd2)))
    else $error("report due with fewer than two peaks");

  div_idle_outside_run_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_OUT) |-> !div_stat.busy)
    else $error("divider busy outside a division state");

endmodule

// ----- bench/breath_and_pulse_rate_monitor_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for the breath and pulse rate monitor: samples in, one
// rate record out per sample, checked against an in-bench predictor.
// Depends on bprm_pkg and breath_and_pulse_rate_monitor.
module breath_and_pulse_rate_monitor_test;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 45;
  localparam int SHOW_LIMIT    = 10;

  typedef struct packed {
    logic [31:0]        time_stamp;
    logic signed [15:0] resp;
    logic signed [15:0] pulse;
  } sample_t;

  typedef struct packed {
    logic        resp_report;
    logic [15:0] resp_rate;
    logic [15:0] resp_rate_min;
    logic [15:0] resp_rate_max;
    logic        pulse_report;
    logic [15:0] pulse_rate;
    logic [15:0] pulse_rate_min;
    logic [15:0] pulse_rate_max;
  } rates_t;

  // per-channel peak history, report phase and held rates
  typedef struct packed {
    logic [1:0][31:0] peak_time;  // [1] newest
    logic [1:0]       peaks;
    logic [15:0]      phase;
    logic [15:0]      rate;
    logic [15:0]      rate_lo;
    logic [15:0]      rate_hi;
  } chan_t;

  logic                              clk_i          = 1'b0;
  logic                              rst_ni         = 1'b0;
  logic                              cfg_valid_i    = 1'b0;
  logic                              cfg_ready_o;
  logic [bprm_pkg::CFG_IDX_BITS-1:0] cfg_index_i    = '0;
  logic [bprm_pkg::CFG_BITS-1:0]     cfg_data_i     = '0;
  logic                              in_valid_i     = 1'b0;
  logic                              in_ready_o;
  logic [31:0]                       time_stamp_i   = '0;
  logic signed [15:0]                resp_sample_i  = '0;
  logic signed [15:0]                pulse_sample_i = '0;
  logic                              out_valid_o;
  logic                              out_ready_i    = 1'b0;
  logic                              resp_report_o;
  logic [bprm_pkg::RATE_BITS-1:0]    resp_rate_o;
  logic [bprm_pkg::RATE_BITS-1:0]    resp_rate_min_o;
  logic [bprm_pkg::RATE_BITS-1:0]    resp_rate_max_o;
  logic                              pulse_report_o;
  logic [bprm_pkg::RATE_BITS-1:0]    pulse_rate_o;
  logic [bprm_pkg::RATE_BITS-1:0]    pulse_rate_min_o;
  logic [bprm_pkg::RATE_BITS-1:0]    pulse_rate_max_o;

  breath_and_pulse_rate_monitor dut (.*);

  always #1 clk_i = ~clk_i;

  // predictor state and register copies
  logic signed [15:0] lvl_arm     = '0;
  logic signed [15:0] lvl_fire    = '0;
  logic signed [15:0] lvl_pulse   = '0;
  logic [15:0]        rate_num    = bprm_pkg::NUMERATOR_RST;
  logic [15:0]        resp_period = bprm_pkg::RESP_PER_RST;
  logic [15:0]        pulse_period = bprm_pkg::PULSE_PER_RST;
  logic signed [15:0] resp_old = '0, resp_mid = '0, pulse_old = '0, pulse_mid = '0;
  logic [31:0]        mid_time = '0;
  logic [1:0]         primed   = '0;
  logic               resp_armed = 1'b0;
  chan_t              resp_ch  = '0;
  chan_t              pulse_ch = '0;

  sample_t samples_waiting[$];
  rates_t  rates_due[$];
  sample_t in_flight;
  int      samples_queued = 0, samples_taken = 0;
  int      send_idle_pct = 0, recv_stall_pct = 0;
  int      mismatches = 0, results_seen = 0, resp_reports = 0, pulse_reports = 0;
  int      settings_used = 0;
  int      quiet_cycles = 0;
  logic [31:0] wave_clock = 32'h0001_0000;

  function automatic void log_peak(inout chan_t ch, input logic [31:0] t);
    ch.peak_time[0] = ch.peak_time[1];
    ch.peak_time[1] = t;
    if (ch.peaks != 2'd2) ch.peaks = ch.peaks + 2'd1;
  endfunction

  function automatic logic report_rate(inout chan_t ch, input logic [15:0] period);
    logic        due;
    logic [16:0] nxt;
    logic [31:0] span;
    logic [15:0] r;
    due = (ch.phase == 16'd0) && (ch.peaks == 2'd2);
    nxt = {1'b0, ch.phase} + 17'd1;
    // a period at or below the count (zero too) restarts the phase
    ch.phase = (nxt >= {1'b0, period}) ? 16'd0 : nxt[15:0];
    if (due) begin
      span = ch.peak_time[1] - ch.peak_time[0];
      r = (span == 32'd0) ? bprm_pkg::RATE_SAT : 16'({16'd0, rate_num} / span);
      ch.rate = r;
      if (ch.rate_lo == 16'd0 || ch.rate_hi == 16'd0) begin
        ch.rate_lo = r;
        ch.rate_hi = r;
      end else begin
        if (r < ch.rate_lo) ch.rate_lo = r;
        if (r > ch.rate_hi) ch.rate_hi = r;
      end
    end
    return due;
  endfunction

  function automatic rates_t predict_rates(input sample_t s);
    rates_t             o;
    logic signed [15:0] r_new, p_new;
    r_new = s.resp;
    p_new = s.pulse;
    if (primed == 2'd2) begin
      // arm is tested before fire, so one sample can do both
      if (resp_mid < lvl_arm && resp_mid > r_new) resp_armed = 1'b1;
      if (resp_mid > lvl_fire && resp_armed) begin
        log_peak(resp_ch, mid_time);
        resp_armed = 1'b0;
      end
      if (pulse_mid >= pulse_old && pulse_mid > p_new && pulse_mid > lvl_pulse)
        log_peak(pulse_ch, mid_time);
    end
    o.resp_report  = report_rate(resp_ch, resp_period);
    o.pulse_report = report_rate(pulse_ch, pulse_period);
    resp_old  = resp_mid;
    resp_mid  = r_new;
    pulse_old = pulse_mid;
    pulse_mid = p_new;
    mid_time  = s.time_stamp;
    if (primed != 2'd2) primed = primed + 2'd1;
    o.resp_rate      = resp_ch.rate;
    o.resp_rate_min  = resp_ch.rate_lo;
    o.resp_rate_max  = resp_ch.rate_hi;
    o.pulse_rate     = pulse_ch.rate;
    o.pulse_rate_min = pulse_ch.rate_lo;
    o.pulse_rate_max = pulse_ch.rate_hi;
    return o;
  endfunction

  // sample driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        rates_due.push_back(predict_rates(in_flight));
        samples_taken++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (samples_waiting.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_flight = samples_waiting.pop_front();
          in_valid_i     <= 1'b1;
          time_stamp_i   <= in_flight.time_stamp;
          resp_sample_i  <= in_flight.resp;
          pulse_sample_i <= in_flight.pulse;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    rates_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{resp_report_o, resp_rate_o, resp_rate_min_o, resp_rate_max_o,
                pulse_report_o, pulse_rate_o, pulse_rate_min_o, pulse_rate_max_o};
        results_seen++;
        resp_reports  += got.resp_report;
        pulse_reports += got.pulse_report;
        if (rates_due.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("%0t: result transaction with nothing expected", $realtime);
        end else begin
          want = rates_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= SHOW_LIMIT) begin
              $display("%0t: result %0d mismatch", $realtime, results_seen);
              $display("  exp resp %b %0d/%0d/%0d pulse %b %0d/%0d/%0d",
                       want.resp_report, want.resp_rate, want.resp_rate_min,
                       want.resp_rate_max, want.pulse_report, want.pulse_rate,
                       want.pulse_rate_min, want.pulse_rate_max);
              $display("  got resp %b %0d/%0d/%0d pulse %b %0d/%0d/%0d",
                       got.resp_report, got.resp_rate, got.resp_rate_min,
                       got.resp_rate_max, got.pulse_report, got.pulse_rate,
                       got.pulse_rate_min, got.pulse_rate_max);
            end
          end
        end
      end
      out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: any accepted transaction restarts the count
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", QUIET_LIMIT);
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [bprm_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [15:0] val);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      bprm_pkg::REG_RESP_ARM:  lvl_arm      = val;
      bprm_pkg::REG_RESP_FIRE: lvl_fire     = val;
      bprm_pkg::REG_PULSE_THR: lvl_pulse    = val;
      bprm_pkg::REG_NUMERATOR: rate_num     = val;
      bprm_pkg::REG_RESP_PER:  resp_period  = val;
      bprm_pkg::REG_PULSE_PER: pulse_period = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(input int arm, input int fire, input int thr,
                          input int num, input int rper, input int pper);
    write_reg(bprm_pkg::REG_RESP_ARM, 16'(arm));
    write_reg(bprm_pkg::REG_RESP_FIRE, 16'(fire));
    write_reg(bprm_pkg::REG_PULSE_THR, 16'(thr));
    write_reg(bprm_pkg::REG_NUMERATOR, 16'(num));
    write_reg(bprm_pkg::REG_RESP_PER, 16'(rper));
    write_reg(bprm_pkg::REG_PULSE_PER, 16'(pper));
    settings_used++;
  endtask

  task automatic queue_sample(input logic [31:0] t, input int r, input int p);
    sample_t s;
    s.time_stamp = t;
    s.resp       = 16'(r);
    s.pulse      = 16'(p);
    samples_waiting.push_back(s);
    samples_queued++;
  endtask

  // sender holds off until every expected result is back
  task automatic wait_drained();
    while (samples_taken != samples_queued || rates_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // breathing as a noisy triangle, pulse as a spike train, some pure noise
  task automatic queue_waveforms(input int count);
    int breath_len, beat_len, amp, d, level, pulse_val;
    breath_len = $urandom_range(4, 40);
    beat_len   = $urandom_range(3, 12);
    amp        = $urandom_range(500, 30000);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 4) begin
        breath_len = $urandom_range(4, 40);
        beat_len   = $urandom_range(3, 12);
        amp        = $urandom_range(500, 30000);
      end
      wave_clock += ($urandom_range(9) == 0) ? 32'd0 : 32'($urandom_range(1, 16));
      if ($urandom_range(149) == 0) wave_clock += $urandom;
      if ($urandom_range(99) < 12) begin
        queue_sample(wave_clock, int'($urandom), int'($urandom));
      end else begin
        d = 2 * (i % breath_len) - breath_len;
        if (d < 0) d = -d;
        level = (2 * amp * d) / breath_len - amp + int'($urandom_range(0, 200)) - 100;
        if (i % beat_len == 0) pulse_val = $urandom_range(20000, 32767);
        else pulse_val = int'($urandom_range(0, 20000)) - 10000;
        queue_sample(wave_clock, level, pulse_val);
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: window fill, arm and fire on one sample, extremes, equal
    // peak times, time stamp wrap; resp reports on every sample once two peaks are seen
    send_idle_pct  = 16;
    recv_stall_pct = 76;
    set_regs(100, -100, -32768, 65535, 0, 1);
    queue_sample(32'd0, 0, 0);
    queue_sample(32'd8, 50, 32767);
    queue_sample(32'd16, -32768, -32768);
    queue_sample(32'd16, 32767, 32767);
    queue_sample(32'd16, 0, 0);
    queue_sample(32'd24, -5, 0);
    queue_sample(32'd24, -10, 32767);
    queue_sample(32'd24, -20, 0);
    queue_sample(32'hFFFF_FFF0, 200, 32767);
    queue_sample(32'h10, -300, 0);
    queue_sample(32'h20, -400, 32767);
    queue_sample(32'h30, -500, -32768);
    queue_sample(32'h40, 32767, -32768);
    queue_sample(32'h50, 0, 0);
    queue_sample(32'hFFFF_FFFF, -32768, -32768);
    queue_sample(32'hFFFF_FFFF, -32768, -32768);
    wait_drained();

    // zero-rate quotients, then a zero interval, then zero again
    set_regs(-32768, 32767, 32766, 1, 2, 0);
    queue_sample(32'd100, 0, 0);
    queue_sample(32'd200, 0, 32767);
    queue_sample(32'd300, 0, 0);
    queue_sample(32'd400, 0, 32767);
    queue_sample(32'd500, 0, 0);
    queue_sample(32'd500, 0, 32767);
    queue_sample(32'd500, 0, 0);
    queue_sample(32'd500, 0, 32767);
    queue_sample(32'd700, 0, 0);
    queue_sample(32'd900, 0, 32767);
    queue_sample(32'd1100, 0, 0);
    wait_drained();

    for (int seg = 0; seg < 6; seg++) begin
      send_idle_pct  = (seg < 2) ? 16 : (seg < 4) ? 76 : 0;
      recv_stall_pct = (seg < 2) ? 76 : (seg < 4) ? 16 : 0;
      case (seg)
        0: set_regs(-3000, 3000, 15000, 60000, 100, 50);
        1: set_regs(-int'($urandom_range(0, 8000)), $urandom_range(0, 8000),
                    $urandom_range(10000, 25000), 65535, 1, 7);
        2: set_regs(32767, -32768, -32768, 1000, 65535, 3);
        3: set_regs(int'($urandom_range(0, 20000)) - 10000,
                    int'($urandom_range(0, 20000)) - 10000,
                    $urandom_range(0, 30000), $urandom_range(1, 65535), 5, 65535);
        4: set_regs(-2000, 2000, 12000, 1, 0, 0);
        default: set_regs(-int'($urandom_range(0, 10000)), $urandom_range(0, 10000),
                          $urandom_range(5000, 25000), $urandom_range(100, 65535),
                          $urandom_range(1, 20), $urandom_range(1, 20));
      endcase
      queue_waveforms(200);
      wait_drained();
    end

    $display("Ran %0d samples under %0d register settings, %0d results checked",
             samples_taken, settings_used, results_seen);
    $display("Rate reports seen: %0d breath, %0d pulse; %0d mismatches",
             resp_reports, pulse_reports, mismatches);
    if (mismatches == 0 && rates_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
